>>> rtl/core/kpdb_pkg.sv
// ----------------------------------------------------------------------------
// kpdb_pkg: shared types and constants for the keypad debounce unit
// Mode encoding, event codes, key decode tables and the result word layout.
// ----------------------------------------------------------------------------
package kpdb_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] IDLE_MARK = 7'h7F;
  localparam logic [CNT_W-1:0] CNT_MAX = 7'd126;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_POLL = 2'd1,
    MODE_LOCK = 2'd2,
    MODE_IACT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_UP   = 2'd1,
    EV_HOLD = 2'd2,
    EV_HLUP = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL     = 2'd0,
    REG_JITTER   = 2'd1,
    REG_HOLD     = 2'd2,
    REG_INACTIVE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    event_t           kind;
    logic [KEY_W-1:0] keys;
    logic [3:0]       value;
    logic [6:0]       char_code;
  } result_t;

  localparam logic [3:0] DIGIT_TABLE [16] = '{
    4'hD, 4'hC, 4'hB, 4'hA, 4'h0, 4'h9, 4'h6, 4'h3,
    4'h0, 4'h8, 4'h5, 4'h2, 4'h0, 4'h7, 4'h4, 4'h1
  };

  // ASCII: D C B A # 9 6 3 0 8 5 2 * 7 4 1
  localparam logic [6:0] CHAR_TABLE [16] = '{
    7'h44, 7'h43, 7'h42, 7'h41, 7'h23, 7'h39, 7'h36, 7'h33,
    7'h30, 7'h38, 7'h35, 7'h32, 7'h2A, 7'h37, 7'h34, 7'h31
  };

  // Index of the lowest set key; only meaningful when keys is non-zero.
  function automatic logic [3:0] lowest_key(input logic [KEY_W-1:0] keys);
    logic [3:0] idx;
    idx = 4'd15;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      if (keys[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  function automatic result_t make_result(input event_t kind,
                                          input logic [KEY_W-1:0] keys);
    result_t    res;
    logic [3:0] idx;
    idx = lowest_key(keys);
    res.kind = kind;
    res.keys = keys;
    if (keys == '0) begin
      res.value = '0;
      res.char_code = '0;
    end else begin
      res.value = DIGIT_TABLE[idx];
      res.char_code = CHAR_TABLE[idx];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/keypad_debounce_hold_events_unit.sv
// ----------------------------------------------------------------------------
// keypad_debounce_hold_events_unit
// Debounces a 4x4 key matrix and reports DOWN, HOLD, UP and HLUP events.
// ----------------------------------------------------------------------------
// Each input word is a timer tick (op 0) or a key change (op 1) carrying the
// matrix reading. The unit takes one word per clock while in_stall is low:
// the state update is registered at the end of the cycle of acceptance, and
// so is any event, into the output register or, if the output is stalled,
// into the skid register behind it. The skid register keeps the input open
// while one event waits; in_stall rises only when both hold an event.
// Configuration writes are always ready and clamp a value of 127 to 126.
module keypad_debounce_hold_events_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [15:0]                          in_scan_bits,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_event_kind,
  output logic [15:0]                          out_keys,
  output logic [3:0]                           out_key_value,
  output logic [6:0]                           out_key_char,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kpdb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kpdb_pkg::CNT_W-1:0]           cfg_data
);

  logic [kpdb_pkg::CNT_W-1:0] poll_r, jitter_r, hold_ticks_r, inact_r;
  logic [kpdb_pkg::CNT_W-1:0] cfg_val;

  kpdb_pkg::mode_t               mode_r, mode_nxt;
  logic [kpdb_pkg::KEY_W-1:0]    held_r, held_nxt;
  logic [kpdb_pkg::CNT_W-1:0]    phase_r, phase_nxt;
  logic [kpdb_pkg::CNT_W-1:0]    hcnt_r, hcnt_nxt;
  logic                          was_held_r, was_held_nxt;

  logic                          in_fire;
  logic                          emit;
  kpdb_pkg::event_t              emit_kind;
  kpdb_pkg::result_t             new_res;

  logic                          out_valid_r, skid_valid_r;
  kpdb_pkg::result_t             out_r, skid_r;
  logic                          out_open;

  logic                          mismatch;
  logic                          release_hit;

  assign cfg_ready = 1'b1;
  assign cfg_val = (cfg_data == kpdb_pkg::IDLE_MARK) ? kpdb_pkg::CNT_MAX : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r       <= 7'd5;
      jitter_r     <= 7'd3;
      hold_ticks_r <= 7'd100;
      inact_r      <= 7'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (kpdb_pkg::cfg_reg_t'(cfg_index))
        kpdb_pkg::REG_POLL:     poll_r <= cfg_val;
        kpdb_pkg::REG_JITTER:   jitter_r <= cfg_val;
        kpdb_pkg::REG_HOLD:     hold_ticks_r <= cfg_val;
        kpdb_pkg::REG_INACTIVE: inact_r <= cfg_val;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign mismatch = (in_scan_bits != held_r);
  assign release_hit = (phase_r != kpdb_pkg::IDLE_MARK) && (phase_r == '0) && mismatch;

  // Next mode.
  always_comb begin
    mode_nxt = mode_r;
    if (in_op) begin
      if (mode_r == kpdb_pkg::MODE_IDLE && in_scan_bits != '0) begin
        mode_nxt = kpdb_pkg::MODE_POLL;
      end
    end else begin
      unique case (mode_r)
        kpdb_pkg::MODE_IDLE: mode_nxt = kpdb_pkg::MODE_IDLE;
        kpdb_pkg::MODE_POLL: begin
          if (phase_r == '0) mode_nxt = kpdb_pkg::MODE_LOCK;
        end
        kpdb_pkg::MODE_LOCK: begin
          if (release_hit) mode_nxt = kpdb_pkg::MODE_IACT;
        end
        kpdb_pkg::MODE_IACT: begin
          if (phase_r == '0) mode_nxt = kpdb_pkg::MODE_IDLE;
        end
        default: mode_nxt = kpdb_pkg::MODE_IDLE;
      endcase
    end
  end

  // Counters, held key set and event selection.
  always_comb begin
    held_nxt     = held_r;
    phase_nxt    = phase_r;
    hcnt_nxt     = hcnt_r;
    was_held_nxt = was_held_r;
    emit         = 1'b0;
    emit_kind    = kpdb_pkg::EV_DOWN;
    if (in_op) begin
      if (mode_r == kpdb_pkg::MODE_IDLE) begin
        if (in_scan_bits != '0) begin
          held_nxt  = in_scan_bits;
          phase_nxt = poll_r;
        end
      end else if (mode_r == kpdb_pkg::MODE_POLL) begin
        held_nxt = held_r | in_scan_bits;
      end
    end else begin
      unique case (mode_r)
        kpdb_pkg::MODE_IDLE: ;
        kpdb_pkg::MODE_POLL: begin
          if (phase_r != '0) begin
            phase_nxt = phase_r - 1'b1;
          end else begin
            was_held_nxt = 1'b0;
            phase_nxt    = kpdb_pkg::IDLE_MARK;
            hcnt_nxt     = hold_ticks_r;
            emit         = 1'b1;
            emit_kind    = kpdb_pkg::EV_DOWN;
          end
        end
        kpdb_pkg::MODE_LOCK: begin
          if (release_hit) begin
            phase_nxt = inact_r;
            emit      = 1'b1;
            emit_kind = was_held_r ? kpdb_pkg::EV_HLUP : kpdb_pkg::EV_UP;
          end else begin
            if (phase_r != kpdb_pkg::IDLE_MARK) begin
              phase_nxt = (phase_r == '0) ? kpdb_pkg::IDLE_MARK : phase_r - 1'b1;
            end else if (mismatch) begin
              phase_nxt = jitter_r;
            end
            if (hcnt_r == '0) begin
              was_held_nxt = 1'b1;
              hcnt_nxt     = kpdb_pkg::IDLE_MARK;
              emit         = 1'b1;
              emit_kind    = kpdb_pkg::EV_HOLD;
            end else if (hcnt_r != kpdb_pkg::IDLE_MARK) begin
              hcnt_nxt = hcnt_r - 1'b1;
            end
          end
        end
        kpdb_pkg::MODE_IACT: begin
          if (phase_r != '0) phase_nxt = phase_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign new_res = kpdb_pkg::make_result(emit_kind, held_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= kpdb_pkg::MODE_IDLE;
      held_r     <= '0;
      phase_r    <= '0;
      hcnt_r     <= '0;
      was_held_r <= 1'b0;
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      held_r     <= held_nxt;
      phase_r    <= phase_nxt;
      hcnt_r     <= hcnt_nxt;
      was_held_r <= was_held_nxt;
    end
  end

  // Output register with a one-word skid stage behind it.
  assign out_open = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_open) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && emit) begin
      if (out_open) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_open) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_open) out_r <= skid_r;
    end else if (in_fire && emit) begin
      if (out_open) begin
        out_r <= new_res;
      end else begin
        skid_r <= new_res;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_r.kind;
  assign out_keys       = out_r.keys;
  assign out_key_value  = out_r.value;
  assign out_key_char   = out_r.char_code;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word present without an output word");

  a_lock_has_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == kpdb_pkg::MODE_LOCK) |-> (held_r != '0))
    else $error("lock state with an empty key set");

  a_event_has_keys: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.keys != '0))
    else $error("event issued with an empty key set");

  a_hold_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit && emit_kind == kpdb_pkg::EV_HOLD) |=> was_held_r)
    else $error("hold event did not mark the key set as held");

endmodule
